// ===== rtl/core/abkf_pkg.sv =====
// Package: shared types and constants for the angle / bias Kalman filter.
package abkf_pkg;

   localparam int unsigned REG_W = 31;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_Q = 2'd0,
      CSR_BIAS_Q  = 2'd1,
      CSR_MEAS_R  = 2'd2,
      CSR_DT      = 2'd3
   } csr_idx_type;

   localparam logic [REG_W-1:0] RST_ANGLE_Q = 31'd1073742;
   localparam logic [REG_W-1:0] RST_BIAS_Q  = 31'd3221225;
   localparam logic [REG_W-1:0] RST_MEAS_R  = 31'd536870912;
   localparam logic [REG_W-1:0] RST_DT      = 31'd21474836;

   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

   // micro-op steps of the sequencer
   typedef enum logic [4:0] {
      OP_ANG_PRED,
      OP_D0,
      OP_P00,
      OP_P01,
      OP_P10,
      OP_P11,
      OP_K0,
      OP_K1,
      OP_C00,
      OP_C01,
      OP_C10,
      OP_C11,
      OP_ERR,
      OP_ANG,
      OP_BIAS,
      OP_RATE
   } op_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -66'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

// ===== rtl/core/angle_bias_kalman_filter.sv =====
// Top level: two-state angle / gyro-bias Kalman filter, one shared multiplier and divider.
//
//  channel | dir | ports                                            | beat
//  req     | in  | req_valid req_stall req_axis_select ...          | one sample
//  rsp     | out | rsp_valid rsp_stall rsp_axis_out ...             | one estimate
//  csr     | in  | csr_write csr_index csr_data                     | one register
//
// Steps: 14 sequencer steps (11 of them multiplies) plus two divider passes
//   (load, 62 restoring steps, gain write each); one sample is in flight at a
//   time, so a new request waits until the result beat is taken. A request for
//   an axis without a filter goes straight to the result beat.
// Reset: synchronous; registers take their defaults, every axis returns to
//   angle 0, bias 0, P = identity. No clearing pass.
// Stalls: one item in flight; req_stall is high from acceptance until the result
//   beat is taken. The result register holds while rsp_stall is high.
module angle_bias_kalman_filter #(
   parameter int unsigned AXIS_COUNT = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_axis_select,
   input  logic signed [31:0] req_measured_angle,
   input  logic signed [31:0] req_gyro_rate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_axis_out,
   output logic signed [31:0] rsp_filtered_angle,
   output logic signed [31:0] rsp_corrected_rate,
   input  logic               csr_write,
   input  logic [abkf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [abkf_pkg::REG_W-1:0]     csr_data
);

   localparam int unsigned AX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   // configuration
   logic [abkf_pkg::REG_W-1:0] qa_ff, qb_ff, rm_ff, dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= abkf_pkg::RST_ANGLE_Q;
         qb_ff <= abkf_pkg::RST_BIAS_Q;
         rm_ff <= abkf_pkg::RST_MEAS_R;
         dt_ff <= abkf_pkg::RST_DT;
      end else if (csr_write) begin
         case (abkf_pkg::csr_idx_type'(csr_index))
            abkf_pkg::CSR_ANGLE_Q: qa_ff <= csr_data;
            abkf_pkg::CSR_BIAS_Q:  qb_ff <= csr_data;
            abkf_pkg::CSR_MEAS_R:  rm_ff <= csr_data;
            abkf_pkg::CSR_DT:      dt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // per-axis state, flops with reset (few entries)
   logic signed [31:0] ang_ff [AXIS_COUNT];
   logic signed [31:0] bia_ff [AXIS_COUNT];
   logic signed [31:0] p00_ff [AXIS_COUNT];
   logic signed [31:0] p01_ff [AXIS_COUNT];
   logic signed [31:0] p10_ff [AXIS_COUNT];
   logic signed [31:0] p11_ff [AXIS_COUNT];

   // working registers
   abkf_pkg::state_type state_ff, state_in;
   abkf_pkg::op_type    op_ff, op_in;
   logic               ax_ff;
   logic               have_ff;       // axis has a filter
   logic signed [31:0] meas_ff, gyro_ff;
   logic signed [31:0] wa_ff, wb_ff;   // predicted then updated angle, old then new bias
   logic signed [31:0] w00_ff, w01_ff, w10_ff, w11_ff, d0_ff;
   logic signed [31:0] k0_ff, k1_ff, err_ff;
   logic signed [31:0] rate_ff;

   // shared multiply: a*b rounded half up, scaled 2^-30
   logic signed [32:0] ma, mb;
   logic signed [65:0] mprod;
   logic signed [35:0] mres;       // rounded product, fits well within
   logic signed [32:0] acc;        // addend
   logic               msub;
   logic signed [31:0] mout;

   assign mprod = ma * mb + 66'sd536870912;
   assign mres  = 36'(mprod >>> 30);
   assign mout  = abkf_pkg::sat32(msub ? 66'(acc) - 66'(mres) : 66'(acc) + 66'(mres));

   logic [AX_W-1:0] ai;
   assign ai = AX_W'(ax_ff);

   always_comb begin
      ma = '0; mb = '0; acc = '0; msub = 1'b0;
      case (op_ff)
         abkf_pkg::OP_ANG_PRED: begin
            ma = 33'(gyro_ff) - 33'(bia_ff[ai]); mb = {2'b0, dt_ff}; acc = 33'(ang_ff[ai]);
         end
         abkf_pkg::OP_P00: begin ma = 33'(d0_ff); mb = {2'b0, dt_ff}; acc = 33'(w00_ff); end
         abkf_pkg::OP_P01: begin
            ma = 33'(w11_ff); mb = {2'b0, dt_ff}; acc = 33'(w01_ff); msub = 1'b1;
         end
         abkf_pkg::OP_P10: begin
            ma = 33'(w11_ff); mb = {2'b0, dt_ff}; acc = 33'(w10_ff); msub = 1'b1;
         end
         abkf_pkg::OP_P11: begin ma = {2'b0, qb_ff}; mb = {2'b0, dt_ff}; acc = 33'(w11_ff); end
         abkf_pkg::OP_C00: begin
            ma = 33'(k0_ff); mb = 33'(w00_ff); acc = 33'(w00_ff); msub = 1'b1;
         end
         abkf_pkg::OP_C01: begin
            ma = 33'(k0_ff); mb = 33'(w01_ff); acc = 33'(w01_ff); msub = 1'b1;
         end
         abkf_pkg::OP_C10: begin
            ma = 33'(k1_ff); mb = 33'(w00_ff); acc = 33'(w10_ff); msub = 1'b1;
         end
         abkf_pkg::OP_C11: begin
            ma = 33'(k1_ff); mb = 33'(w01_ff); acc = 33'(w11_ff); msub = 1'b1;
         end
         abkf_pkg::OP_ANG: begin ma = 33'(k0_ff); mb = 33'(err_ff); acc = 33'(wa_ff); end
         abkf_pkg::OP_BIAS: begin ma = 33'(k1_ff); mb = 33'(err_ff); acc = 33'(bia_ff[ai]); end
         default: ;
      endcase
   end

   // restoring divider: |num| * 2^30 / den, 62 quotient bits
   logic [61:0] dq_ff;      // dividend shifting out / quotient shifting in
   logic [32:0] drem_ff;
   logic [31:0] dden_ff;
   logic        dneg_ff;
   logic [5:0]  dcnt_ff;
   logic [33:0] dtrial;
   assign dtrial = {drem_ff, dq_ff[61]} - {2'b0, dden_ff};

   logic signed [32:0] e_sum;
   assign e_sum = 33'({2'b0, rm_ff}) + 33'(w00_ff);
   logic signed [31:0] dnum;
   assign dnum = (op_ff == abkf_pkg::OP_K0) ? w00_ff : w10_ff;
   logic [31:0] dnum_abs;
   assign dnum_abs = dnum[31] ? 32'(-33'(dnum)) : dnum;

   logic signed [65:0] dsigned;
   assign dsigned = dneg_ff ? -66'({4'b0, dq_ff}) : 66'({4'b0, dq_ff});

   logic start;
   assign start = (state_ff == abkf_pkg::ST_IDLE) && req_valid;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      case (state_ff)
         abkf_pkg::ST_IDLE:
            if (req_valid) state_in = (32'(req_axis_select) < AXIS_COUNT) ?
                                      abkf_pkg::ST_MUL : abkf_pkg::ST_OUT;
         abkf_pkg::ST_MUL: begin
            case (op_ff)
               abkf_pkg::OP_P11: begin
                  op_in = abkf_pkg::OP_K0; state_in = abkf_pkg::ST_DIV_INIT;
               end
               abkf_pkg::OP_C11: op_in = abkf_pkg::OP_ERR;
               abkf_pkg::OP_BIAS: op_in = abkf_pkg::OP_RATE;
               abkf_pkg::OP_RATE: state_in = abkf_pkg::ST_OUT;
               default: op_in = abkf_pkg::op_type'(op_ff + 5'd1);
            endcase
         end
         abkf_pkg::ST_DIV_INIT: state_in = abkf_pkg::ST_DIV;
         abkf_pkg::ST_DIV:
            if (dcnt_ff == 6'd0) begin
               if (op_ff == abkf_pkg::OP_K0) begin
                  op_in = abkf_pkg::OP_K1; state_in = abkf_pkg::ST_DIV_INIT;
               end else begin
                  op_in = abkf_pkg::OP_C00; state_in = abkf_pkg::ST_MUL;
               end
            end
         abkf_pkg::ST_OUT:
            if (!rsp_stall) state_in = abkf_pkg::ST_IDLE;
         default: state_in = abkf_pkg::ST_IDLE;
      endcase
      if (start) op_in = abkf_pkg::OP_ANG_PRED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abkf_pkg::ST_IDLE;
         op_ff <= abkf_pkg::OP_ANG_PRED;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff <= req_axis_select;
         have_ff <= 32'(req_axis_select) < AXIS_COUNT;
         meas_ff <= req_measured_angle;
         gyro_ff <= req_gyro_rate;
         rate_ff <= req_gyro_rate;
      end
      if (state_ff == abkf_pkg::ST_MUL) begin
         case (op_ff)
            abkf_pkg::OP_ANG_PRED: begin
               wa_ff <= mout; wb_ff <= bia_ff[ai];
               w00_ff <= p00_ff[ai]; w01_ff <= p01_ff[ai];
               w10_ff <= p10_ff[ai]; w11_ff <= p11_ff[ai];
            end
            abkf_pkg::OP_D0: d0_ff <= abkf_pkg::sat32(66'({1'b0, qa_ff})
                                      - 66'(w01_ff) - 66'(w10_ff));
            abkf_pkg::OP_P00: w00_ff <= mout;
            abkf_pkg::OP_P01: w01_ff <= mout;
            abkf_pkg::OP_P10: w10_ff <= mout;
            abkf_pkg::OP_P11: w11_ff <= mout;
            abkf_pkg::OP_ERR: err_ff <= abkf_pkg::sat32(66'(meas_ff) - 66'(wa_ff));
            abkf_pkg::OP_ANG: wa_ff <= mout;
            abkf_pkg::OP_BIAS: wb_ff <= mout;
            abkf_pkg::OP_RATE: rate_ff <= abkf_pkg::sat32(66'(gyro_ff) - 66'(wb_ff));
            default: ;
         endcase
      end
      if (state_ff == abkf_pkg::ST_DIV_INIT) begin
         dq_ff <= {dnum_abs[31:0], 30'd0};
         drem_ff <= '0;
         dden_ff <= e_sum[32] || (e_sum == '0) ? 32'd1 : e_sum[31:0];
         dneg_ff <= dnum[31];
         dcnt_ff <= 6'd62;
      end
      if (state_ff == abkf_pkg::ST_DIV) begin
         if (dcnt_ff != 6'd0) begin
            if (!dtrial[33]) begin
               drem_ff <= dtrial[32:0];
               dq_ff <= {dq_ff[60:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[31:0], dq_ff[61]};
               dq_ff <= {dq_ff[60:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 6'd1;
         end else if (op_ff == abkf_pkg::OP_K0) begin
            k0_ff <= abkf_pkg::sat32(dsigned);
         end else begin
            k1_ff <= abkf_pkg::sat32(dsigned);
         end
      end
   end

   // axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            ang_ff[i] <= '0; bia_ff[i] <= '0;
            p00_ff[i] <= abkf_pkg::Q30_ONE; p01_ff[i] <= '0;
            p10_ff[i] <= '0; p11_ff[i] <= abkf_pkg::Q30_ONE;
         end
      end else if (state_ff == abkf_pkg::ST_MUL) begin
         case (op_ff)
            abkf_pkg::OP_C00: p00_ff[ai] <= mout;
            abkf_pkg::OP_C01: p01_ff[ai] <= mout;
            abkf_pkg::OP_C10: p10_ff[ai] <= mout;
            abkf_pkg::OP_C11: p11_ff[ai] <= mout;
            abkf_pkg::OP_ANG: ang_ff[ai] <= mout;
            abkf_pkg::OP_BIAS: bia_ff[ai] <= mout;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != abkf_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == abkf_pkg::ST_OUT);
   assign rsp_axis_out = ax_ff;
   assign rsp_filtered_angle = have_ff ? wa_ff : '0;
   assign rsp_corrected_rate = rate_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result shown while idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abkf_pkg::ST_DIV) |-> (dcnt_ff <= 6'd62)) else $error("divider count");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("stall not raised");

endmodule
